// File: rtl/fas_pkg.sv
// fas_pkg: widths and item types for the fraction add/subtract block
// no dependencies; imported by fas_div and fraction_add_subtract_top
package fas_pkg;

  // field widths
  localparam int NUM_WIDTH  = 16;
  localparam int DEN_WIDTH  = 16;
  localparam int RES_NUM_W  = 33;
  localparam int RES_DEN_W  = 32;

  // divider step counter and gcd shift counter widths
  localparam int CNT_W = $clog2(DEN_WIDTH + 1);
  localparam int K_W   = $clog2(DEN_WIDTH);

  // shared multiplier: signed operand a covers numerators and denominators
  localparam int MA_W  = ((NUM_WIDTH > DEN_WIDTH) ? NUM_WIDTH : DEN_WIDTH) + 1;
  localparam int MB_W  = DEN_WIDTH + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int SUM_W = P_W + 1;

  // operation codes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  typedef logic [DEN_WIDTH-1:0] den_t;

  typedef struct packed {
    logic                        operation;
    logic signed [NUM_WIDTH-1:0] num_a;
    logic [DEN_WIDTH-1:0]        den_a;
    logic signed [NUM_WIDTH-1:0] num_b;
    logic [DEN_WIDTH-1:0]        den_b;
  } fas_in_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] result_num;
    logic [RES_DEN_W-1:0]        result_den;
    logic                        bad_denominator;
  } fas_out_t;

endpackage

// File: rtl/fraction_add_subtract_top.sv
// fraction_add_subtract_top: adds or subtracts two fractions over their lcm
// depends on fas_pkg and fas_div
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result appears for one cycle with out_valid, and the receiver
// must take it then. Before the result strobe come, in order: a binary gcd
// loop (data dependent), two 16-step divisions on the shared divider, three
// passes through one shared multiplier and a final add. An item with a zero
// denominator skips straight to the final state and returns zeros with
// bad_denominator set.
module fraction_add_subtract_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fas_pkg::fas_in_t  in_item,
  output logic              out_valid,
  output fas_pkg::fas_out_t out_item
);
  import fas_pkg::*;

  // sequencer codes
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_GCD     = 4'd1;
  localparam logic [3:0] ST_QB_GO   = 4'd2;
  localparam logic [3:0] ST_QB_WAIT = 4'd3;
  localparam logic [3:0] ST_QA_GO   = 4'd4;
  localparam logic [3:0] ST_QA_WAIT = 4'd5;
  localparam logic [3:0] ST_MUL_L   = 4'd6;
  localparam logic [3:0] ST_MUL_A   = 4'd7;
  localparam logic [3:0] ST_MUL_B   = 4'd8;
  localparam logic [3:0] ST_SUM     = 4'd9;

  logic [3:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  fas_out_t                    out_item_r, out_item_nxt;

  // operand registers
  logic                        sub_r, sub_nxt;
  logic                        bad_r, bad_nxt;
  logic signed [NUM_WIDTH-1:0] na_r, na_nxt;
  logic signed [NUM_WIDTH-1:0] nb_r, nb_nxt;
  den_t                        da_r, da_nxt;
  den_t                        db_r, db_nxt;

  // gcd loop registers
  den_t                        x_r, x_nxt;
  den_t                        y_r, y_nxt;
  logic [K_W-1:0]              k_r, k_nxt;
  den_t                        g_r, g_nxt;

  // quotients and products
  den_t                        qa_r, qa_nxt;
  den_t                        qb_r, qb_nxt;
  logic signed [P_W-1:0]       prod_r, prod_nxt;
  logic signed [P_W-1:0]       sa_r, sa_nxt;
  logic [RES_DEN_W-1:0]        lcm_r, lcm_nxt;

  logic                        accept;
  logic [DEN_WIDTH:0]          d_xy;
  logic [DEN_WIDTH:0]          d_yx;
  logic                        div_start;
  den_t                        div_dividend;
  logic                        div_done;
  den_t                        div_quot;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [SUM_W-1:0]     sum_a;
  logic signed [SUM_W-1:0]     sum_b;
  logic signed [SUM_W-1:0]     sum_r;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // gcd subtractor, compare from the borrow
  assign d_xy = {1'b0, x_r} - {1'b0, y_r};
  assign d_yx = {1'b0, y_r} - {1'b0, x_r};

  // shared divider: db/g first, then da/g
  assign div_start    = (state_r == ST_QB_GO) || (state_r == ST_QA_GO);
  assign div_dividend = (state_r == ST_QB_GO) ? db_r : da_r;

  fas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_MUL_A: begin
        mul_a = MA_W'(na_r);
        mul_b = {1'b0, qb_r};
      end
      ST_MUL_B: begin
        mul_a = MA_W'(nb_r);
        mul_b = {1'b0, qa_r};
      end
      default: begin
        mul_a = MA_W'(da_r);
        mul_b = {1'b0, qb_r};
      end
    endcase
  end

  // final add or subtract
  assign sum_a = SUM_W'(sa_r);
  assign sum_b = SUM_W'(prod_r);
  assign sum_r = (sub_r == OP_SUB) ? (sum_a - sum_b) : (sum_a + sum_b);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    sub_nxt       = sub_r;
    bad_nxt       = bad_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    prod_nxt      = prod_r;
    sa_nxt        = sa_r;
    lcm_nxt       = lcm_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sub_nxt = in_item.operation;
          na_nxt  = in_item.num_a;
          nb_nxt  = in_item.num_b;
          da_nxt  = in_item.den_a;
          db_nxt  = in_item.den_b;
          x_nxt   = in_item.den_a;
          y_nxt   = in_item.den_b;
          k_nxt   = '0;
          bad_nxt = (in_item.den_a == '0) || (in_item.den_b == '0);
          state_nxt = bad_nxt ? ST_SUM : ST_GCD;
        end
      end
      // binary gcd, one step per cycle
      ST_GCD: begin
        if (x_r == '0) begin
          g_nxt     = y_r << k_r;
          state_nxt = ST_QB_GO;
        end else if (y_r == '0) begin
          g_nxt     = x_r << k_r;
          state_nxt = ST_QB_GO;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + K_W'(1);
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (!d_xy[DEN_WIDTH]) begin
          x_nxt = d_xy[DEN_WIDTH:1];
        end else begin
          y_nxt = d_yx[DEN_WIDTH:1];
        end
      end
      ST_QB_GO: begin
        state_nxt = ST_QB_WAIT;
      end
      ST_QB_WAIT: begin
        if (div_done) begin
          qb_nxt    = div_quot;
          state_nxt = ST_QA_GO;
        end
      end
      ST_QA_GO: begin
        state_nxt = ST_QA_WAIT;
      end
      ST_QA_WAIT: begin
        if (div_done) begin
          qa_nxt    = div_quot;
          state_nxt = ST_MUL_L;
        end
      end
      // lcm = da * (db / g)
      ST_MUL_L: begin
        prod_nxt  = P_W'(mul_a) * P_W'(mul_b);
        state_nxt = ST_MUL_A;
      end
      // na * (db / g)
      ST_MUL_A: begin
        lcm_nxt   = prod_r[RES_DEN_W-1:0];
        prod_nxt  = P_W'(mul_a) * P_W'(mul_b);
        state_nxt = ST_MUL_B;
      end
      // nb * (da / g)
      ST_MUL_B: begin
        sa_nxt    = prod_r;
        prod_nxt  = P_W'(mul_a) * P_W'(mul_b);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        out_valid_nxt = 1'b1;
        if (bad_r) begin
          out_item_nxt.result_num      = '0;
          out_item_nxt.result_den      = '0;
          out_item_nxt.bad_denominator = 1'b1;
        end else begin
          out_item_nxt.result_num      = sum_r[RES_NUM_W-1:0];
          out_item_nxt.result_den      = lcm_r;
          out_item_nxt.bad_denominator = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    sub_r      <= sub_nxt;
    bad_r      <= bad_nxt;
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    k_r        <= k_nxt;
    g_r        <= g_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    prod_r     <= prod_nxt;
    sa_r       <= sa_nxt;
    lcm_r      <= lcm_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // an accepted item holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  // result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // error result carries zeros
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_denominator) |->
      (out_item.result_num == '0 && out_item.result_den == '0))
    else $error("error result not zeroed");

  // a good item never yields a zero lcm
  a_lcm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.bad_denominator) |-> out_item.result_den != '0)
    else $error("zero lcm on good item");

  // gcd never starts a division by zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> g_r != '0)
    else $error("division by zero gcd");

endmodule

// File: rtl/fas_div.sv
// fas_div: iterative restoring divider, one quotient bit per cycle
// depends on fas_pkg for the denominator width and counter width
module fas_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  fas_pkg::den_t dividend,
  input  fas_pkg::den_t divisor,
  output logic         done,
  output fas_pkg::den_t quotient
);
  import fas_pkg::*;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  den_t               rem_r, rem_nxt;
  den_t               quo_r, quo_nxt;
  den_t               dsr_r, dsr_nxt;
  logic [DEN_WIDTH:0] shifted;
  logic [DEN_WIDTH:0] trial;

  // shift in the next dividend bit and try the subtract
  assign shifted = {rem_r, quo_r[DEN_WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    done_nxt = (cnt_r == CNT_W'(1));
    if (start) begin
      cnt_nxt  = CNT_W'(DEN_WIDTH);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      quo_nxt = {quo_r[DEN_WIDTH-2:0], ~trial[DEN_WIDTH]};
      if (!trial[DEN_WIDTH]) begin
        rem_nxt = trial[DEN_WIDTH-1:0];
      end else begin
        rem_nxt = shifted[DEN_WIDTH-1:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // done comes only once the step count has run out
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == '0)
    else $error("divider done while still stepping");

  // a start loads the full step count
  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == CNT_W'(DEN_WIDTH))
    else $error("divider start did not load step count");

  // done follows the last step
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_W'(1) && !start) |=> done_r)
    else $error("divider missed done");

endmodule

// File: tb/fraction_add_subtract_checker.sv
`timescale 1ns / 1ps
// fraction_add_subtract_checker: watches both channels of the fraction block,
// predicts each result and compares it field by field; depends on fas_pkg
module fraction_add_subtract_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  fas_pkg::fas_in_t       in_item,
  input  logic                   out_valid,
  input  fas_pkg::fas_out_t      out_item,
  output int unsigned            errors,
  output int unsigned            pending,
  output int unsigned            results_seen,
  output int unsigned            bad_den_seen
);
  import fas_pkg::*;

  fas_out_t expected_sums[$];
  fas_out_t want;

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    bad_den_seen = 0;
  end

  // sum or difference over the lcm, 64-bit two's complement then truncated
  function automatic fas_out_t predict_sum(fas_in_t it);
    logic [63:0] na, nb, da, db, x, y, t, lcm, sa, sb, r;
    fas_out_t res;
    na = {{(64-NUM_WIDTH){it.num_a[NUM_WIDTH-1]}}, it.num_a};
    nb = {{(64-NUM_WIDTH){it.num_b[NUM_WIDTH-1]}}, it.num_b};
    da = {{(64-DEN_WIDTH){1'b0}}, it.den_a};
    db = {{(64-DEN_WIDTH){1'b0}}, it.den_b};
    res = '0;
    if (da == 0 || db == 0) begin
      res.bad_denominator = 1'b1;
      return res;
    end
    // euclid on the denominators
    x = da;
    y = db;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    lcm = (da * db) / x;
    sa  = na * (lcm / da);
    sb  = nb * (lcm / db);
    r   = (it.operation == OP_SUB) ? (sa - sb) : (sa + sb);
    res.result_num      = r[RES_NUM_W-1:0];
    res.result_den      = lcm[RES_DEN_W-1:0];
    res.bad_denominator = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, fas_out_t got, fas_out_t exp_res);
    errors++;
    if (errors <= 20)
      $display("[%0t] mismatch on %s: got %0d/%0d bad=%0b, expected %0d/%0d bad=%0b",
               $realtime, what, got.result_num, got.result_den, got.bad_denominator,
               exp_res.result_num, exp_res.result_den, exp_res.bad_denominator);
  endtask

  // results are taken first so an item accepted on the same edge waits its turn
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (out_item.bad_denominator) bad_den_seen++;
        if (expected_sums.size() == 0) begin
          report_mismatch("result with no item outstanding", out_item, '0);
        end else begin
          want = expected_sums.pop_front();
          if (out_item.result_num !== want.result_num)
            report_mismatch("result_num", out_item, want);
          if (out_item.result_den !== want.result_den)
            report_mismatch("result_den", out_item, want);
          if (out_item.bad_denominator !== want.bad_denominator)
            report_mismatch("bad_denominator", out_item, want);
        end
      end
      if (start && !busy) expected_sums.push_back(predict_sum(in_item));
      pending = expected_sums.size();
    end
  end

endmodule

// File: tb/fraction_add_subtract_top_tb.sv
`timescale 1ns / 1ps
// fraction_add_subtract_top_tb: directed and random fraction items with random
// gaps; depends on fas_pkg, fraction_add_subtract_top and the checker module
module fraction_add_subtract_top_tb;
  import fas_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  fas_in_t     in_item;
  logic        out_valid;
  fas_out_t    out_item;
  int unsigned errors, pending, results_seen, bad_den_seen;
  int unsigned items_sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fraction_add_subtract_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  fraction_add_subtract_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .bad_den_seen (bad_den_seen)
  );

  // numerators: mostly uniform, sometimes an extreme
  function automatic logic [NUM_WIDTH-1:0] random_num();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      default: return NUM_WIDTH'($urandom_range(0, 65535));
    endcase
  endfunction

  // nonzero denominators of several shapes
  function automatic den_t random_den();
    case ($urandom_range(0, 7))
      0: return den_t'($urandom_range(1, 16));
      1: return den_t'(1) << $urandom_range(0, DEN_WIDTH - 1);
      2: return den_t'($urandom_range(65000, 65535));
      default: return den_t'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic fas_in_t make_item();
    fas_in_t     it;
    int unsigned sel, g;
    it.operation = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
    it.num_a     = random_num();
    it.num_b     = random_num();
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      it.den_a = '0;
      it.den_b = random_den();
    end else if (sel < 4) begin
      it.den_a = random_den();
      it.den_b = '0;
    end else if (sel < 5) begin
      it.den_a = '0;
      it.den_b = '0;
    end else if (sel < 40) begin
      // denominators with a common factor
      g = $urandom_range(1, 255);
      it.den_a = den_t'(g * $urandom_range(1, 256));
      it.den_b = den_t'(g * $urandom_range(1, 256));
    end else begin
      it.den_a = random_den();
      it.den_b = random_den();
    end
    return it;
  endfunction

  // hold start until the block takes the item
  task automatic send_item(fas_in_t it);
    @(negedge clk);
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // drop start with junk on the data lines; n sets the length of the gap
  task automatic idle(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      start   = 1'b0;
      in_item = make_item();
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int unsigned random_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 9) < 6) return 0;
    return $urandom_range(1, 3);
  endfunction

  task automatic directed(logic op, logic [NUM_WIDTH-1:0] na, den_t da,
                          logic [NUM_WIDTH-1:0] nb, den_t db);
    fas_in_t it;
    it.operation = op;
    it.num_a     = na;
    it.den_a     = da;
    it.num_b     = nb;
    it.den_b     = db;
    send_item(it);
    idle(random_gap());
  endtask

  // stop sending, then wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // run time limit
  initial begin
    #4_000_000;
    $display("fraction_add_subtract_top_tb NOT OK");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: small cases, extreme numerators and denominators, zero denominators
    directed(OP_ADD, 16'd1,    16'd2,     16'd1,    16'd3);
    directed(OP_SUB, 16'd1,    16'd2,     16'd1,    16'd3);
    directed(OP_ADD, 16'h7fff, 16'd1,     16'h7fff, 16'd1);
    directed(OP_SUB, 16'h8000, 16'd1,     16'h7fff, 16'd1);
    directed(OP_ADD, 16'h8000, 16'd65535, 16'h8000, 16'd65534);
    directed(OP_SUB, 16'h8000, 16'd65535, 16'h7fff, 16'd65534);
    directed(OP_SUB, 16'h7fff, 16'd65535, 16'h8000, 16'd65534);
    directed(OP_ADD, 16'h7fff, 16'd65534, 16'h7fff, 16'd65535);
    directed(OP_ADD, 16'd5,    16'd0,     16'd1,    16'd3);
    directed(OP_SUB, 16'd1,    16'd3,     16'd5,    16'd0);
    directed(OP_ADD, 16'd0,    16'd0,     16'd0,    16'd0);
    directed(OP_SUB, 16'h8000, 16'd0,     16'h7fff, 16'd65535);
    directed(OP_ADD, 16'd7,    16'd65535, 16'd3,    16'd65535);
    directed(OP_ADD, 16'd1,    16'd4,     16'd1,    16'd8);
    directed(OP_SUB, 16'd0,    16'd1,     16'd0,    16'd1);
    directed(OP_ADD, 16'hffff, 16'd1,     16'hffff, 16'd1);
    directed(OP_ADD, 16'd3,    16'd32768, 16'd5,    16'd65535);
    directed(OP_SUB, 16'd1,    16'd12,    16'd1,    16'd18);
    directed(OP_ADD, 16'h7fff, 16'd65535, 16'h8000, 16'd1);
    directed(OP_SUB, 16'hffff, 16'd65521, 16'd1,    16'd65519);
    directed(OP_ADD, 16'd1,    16'd1,     16'd1,    16'd65535);
    directed(OP_SUB, 16'd12345, 16'd1024, 16'hadd8, 16'd768);

    // let everything drain once before the random part
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_item(make_item());
      if (i == RANDOM_ITEMS / 2) wait_drained();
      // back-to-back stretches of 50 items in every 250 items
      if ((i % 250) >= 50) idle(random_gap());
    end
    idle(1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d items sent, %0d results checked, %0d flagged bad denominator",
             items_sent, results_seen, bad_den_seen);
    $display("directed extremes plus random add/subtract over mixed and shared denominators");
    if (errors == 0)
      $display("fraction_add_subtract_top_tb OK");
    else
      $display("fraction_add_subtract_top_tb NOT OK");
    $finish;
  end

endmodule
